FILE: rtl/trc_pkg.sv
// types and constants shared by the three-rotor cipher modules
`timescale 1ns / 1ps
`default_nettype none

package trc_pkg;

   localparam int ALPHA_SIZE = 26;
   localparam int NUM_ROTORS = 3;
   localparam int IDX_W      = 5;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_CHAR = 1'b1;

   localparam logic [7:0] LOWER_FIRST = 8'd97;
   localparam logic [7:0] LOWER_LAST  = 8'd122;
   localparam logic [7:0] UPPER_FIRST = 8'd65;
   localparam logic [7:0] UPPER_LAST  = 8'd90;

   localparam logic [IDX_W-1:0] LAST_LETTER = IDX_W'(ALPHA_SIZE - 1);

   typedef struct packed {
      logic                                  opcode;
      logic                                  letter;
      logic                                  upper;
      logic [7:0]                            char_raw;
      logic [1:0]                            sel;
      logic [IDX_W-1:0]                      idx;
      logic [IDX_W-1:0]                      val;
      logic [IDX_W-1:0]                      data;
      logic [NUM_ROTORS-1:0][IDX_W-1:0]      offs;
   } item_type;

endpackage

`default_nettype wire

FILE: rtl/trc_front.sv
// request decode and rotor offset odometer
`timescale 1ns / 1ps
`default_nettype none

module trc_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          take,
   input  wire logic                          opcode,
   input  wire logic [1:0]                    rotor_select,
   input  wire logic [trc_pkg::IDX_W-1:0]     entry_index,
   input  wire logic [trc_pkg::IDX_W-1:0]     entry_value,
   input  wire logic [7:0]                    char_in,
   output trc_pkg::item_type                  item
);

   logic [trc_pkg::IDX_W-1:0] off1_ff, off2_ff, off3_ff;
   logic [trc_pkg::IDX_W-1:0] off1_in, off2_in, off3_in;
   logic                      is_lower, is_upper, step;
   logic [trc_pkg::IDX_W-1:0] diff;
   logic                      wrap1, wrap2;

   assign is_lower = (char_in >= trc_pkg::LOWER_FIRST) && (char_in <= trc_pkg::LOWER_LAST);
   assign is_upper = (char_in >= trc_pkg::UPPER_FIRST) && (char_in <= trc_pkg::UPPER_LAST);
   assign diff     = trc_pkg::IDX_W'(char_in - (is_upper ? trc_pkg::UPPER_FIRST
                                                         : trc_pkg::LOWER_FIRST));
   assign step     = take && (opcode == trc_pkg::OP_CHAR) && (is_lower || is_upper);
   assign wrap1    = (off1_ff == trc_pkg::LAST_LETTER);
   assign wrap2    = (off2_ff == trc_pkg::LAST_LETTER);

   always_comb begin
      off1_in = off1_ff;
      off2_in = off2_ff;
      off3_in = off3_ff;
      if (step) begin
         off1_in = wrap1 ? '0 : off1_ff + 1'b1;
         if (wrap1) begin
            off2_in = wrap2 ? '0 : off2_ff + 1'b1;
            if (wrap2) begin
               off3_in = (off3_ff == trc_pkg::LAST_LETTER) ? '0 : off3_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off1_ff <= '0;
         off2_ff <= '0;
         off3_ff <= '0;
      end else begin
         off1_ff <= off1_in;
         off2_ff <= off2_in;
         off3_ff <= off3_in;
      end
   end

   always_comb begin
      item          = '0;
      item.opcode   = opcode;
      item.letter   = is_lower || is_upper;
      item.upper    = is_upper;
      item.char_raw = char_in;
      item.sel      = rotor_select;
      item.idx      = entry_index;
      item.val      = (entry_value >= trc_pkg::IDX_W'(trc_pkg::ALPHA_SIZE))
                      ? entry_value - trc_pkg::IDX_W'(trc_pkg::ALPHA_SIZE) : entry_value;
      item.data     = diff;
      item.offs[0]  = off1_ff;
      item.offs[1]  = off2_ff;
      item.offs[2]  = off3_ff;
   end

endmodule

`default_nettype wire

FILE: rtl/trc_rotor_cell.sv
// one rotor cell: table storage, offset lookup and a pipeline register
`timescale 1ns / 1ps
`default_nettype none

module trc_rotor_cell #(
   parameter int ROTOR_ID = 0
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   output logic              in_ready,
   input  trc_pkg::item_type in_item,
   output logic              out_valid,
   input  wire logic         out_ready,
   output trc_pkg::item_type out_item
);

   localparam bit LAST_CELL = (ROTOR_ID == trc_pkg::NUM_ROTORS - 1);

   logic [trc_pkg::IDX_W-1:0] rotor_ff [trc_pkg::ALPHA_SIZE];
   logic                      valid_ff, valid_in;
   trc_pkg::item_type         item_ff, item_in;
   logic                      take, keep, is_write;
   logic [trc_pkg::IDX_W:0]   sum;
   logic [trc_pkg::IDX_W-1:0] pos;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;
   assign keep     = !LAST_CELL || (in_item.opcode == trc_pkg::OP_CHAR);
   assign is_write = take && (in_item.opcode == trc_pkg::OP_LOAD)
                     && (in_item.sel == 2'(ROTOR_ID))
                     && (in_item.idx < trc_pkg::IDX_W'(trc_pkg::ALPHA_SIZE));

   assign sum = {1'b0, in_item.data} + {1'b0, in_item.offs[ROTOR_ID]};
   assign pos = (sum >= (trc_pkg::IDX_W+1)'(trc_pkg::ALPHA_SIZE))
                ? trc_pkg::IDX_W'(sum - (trc_pkg::IDX_W+1)'(trc_pkg::ALPHA_SIZE))
                : sum[trc_pkg::IDX_W-1:0];

   always_comb begin
      item_in = in_item;
      if (in_item.opcode == trc_pkg::OP_CHAR && in_item.letter) begin
         item_in.data = rotor_ff[pos];
      end
   end

   always_comb begin
      if (take) begin
         valid_in = keep;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (is_write) begin
         rotor_ff[in_item.idx] <= in_item.val;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

FILE: rtl/three_rotor_cipher_unit.sv
// top level of the three-rotor substitution cipher
`timescale 1ns / 1ps
`default_nettype none

// Accepts one request per cycle unless req_stall is high. A load request writes
// one entry of one rotor table and gives no response; a character request gives
// exactly one response, in request order. Requests flow through a chain of three
// rotor cells, each owning one rotor table and a pipeline register, so a response
// passes the pipeline registers of cells 0, 1 and 2 in turn before it is presented,
// and is held in the last cell while the response side stalls. Each cell passes
// one request per cycle through its pipeline register while the next cell is ready.
// The rotor offsets step as each letter is taken, and a load is seen by every
// character request taken after it.
module three_rotor_cipher_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_opcode,
   input  wire logic [1:0] req_rotor_select,
   input  wire logic [4:0] req_entry_index,
   input  wire logic [4:0] req_entry_value,
   input  wire logic [7:0] req_char_in,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_char_out
);

   trc_pkg::item_type                  front_item;
   trc_pkg::item_type                  link_item  [trc_pkg::NUM_ROTORS+1];
   logic [trc_pkg::NUM_ROTORS:0]       link_valid;
   logic [trc_pkg::NUM_ROTORS:0]       link_ready;
   logic                               take;
   trc_pkg::item_type                  last_item;
   logic [7:0]                         base;

   assign take          = req_valid && link_ready[0];
   assign req_stall     = !link_ready[0];
   assign link_valid[0] = req_valid;
   assign link_item[0]  = front_item;

   trc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .opcode       (req_opcode),
      .rotor_select (req_rotor_select),
      .entry_index  (req_entry_index),
      .entry_value  (req_entry_value),
      .char_in      (req_char_in),
      .item         (front_item)
   );

   for (genvar g = 0; g < trc_pkg::NUM_ROTORS; g++) begin : g_cell
      trc_rotor_cell #(
         .ROTOR_ID (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[g]),
         .in_ready  (link_ready[g]),
         .in_item   (link_item[g]),
         .out_valid (link_valid[g+1]),
         .out_ready (link_ready[g+1]),
         .out_item  (link_item[g+1])
      );
   end

   assign link_ready[trc_pkg::NUM_ROTORS] = !rsp_stall;
   assign last_item = link_item[trc_pkg::NUM_ROTORS];
   assign rsp_valid = link_valid[trc_pkg::NUM_ROTORS];

   assign base         = last_item.upper ? trc_pkg::UPPER_FIRST : trc_pkg::LOWER_FIRST;
   assign rsp_char_out = last_item.letter ? base + {3'b000, last_item.data}
                                          : last_item.char_raw;

endmodule

`default_nettype wire
